[src/alb_pkg.sv]
// Shared types and constants of the antialiased line blender.
// Holds the word formats, command kinds and the queue entry type.
// Depends on nothing; every other file imports it.
`default_nettype none
package alb_pkg;

  localparam int COORD_W        = 20;
  localparam int GRAD_FRAC      = 16;
  localparam int SIZE_W         = 11;
  localparam int CFG_W          = 7;
  localparam int CFG_IDX_W      = 1;
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int DEF_COORD_FRAC = 8;

  localparam logic [CFG_W-1:0] RESET_SIZE = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [1:0] KIND_DRAW  = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]                kind;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic [7:0]                red;
    logic [7:0]                green;
    logic [7:0]                blue;
    logic [5:0]                read_col;
    logic [5:0]                read_row;
  } in_word_t;

  typedef struct packed {
    logic       is_read_data;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } out_word_t;

  // A classified command: the line is already in its steep-swapped,
  // left-to-right form.
  typedef struct packed {
    logic [1:0]                kind;
    logic                      steep;
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] x1;
    logic [COORD_W-1:0]        dx;
    logic [COORD_W-1:0]        dy_mag;
    logic                      dy_neg;
    logic [23:0]               color;
    logic [5:0]                read_col;
    logic [5:0]                read_row;
  } cmd_t;

endpackage
`default_nettype wire

[src/alb_front.sv]
// Front end of the line blender: accepts command words, classifies lines
// (steep and endpoint swaps) and queues them for the back end.
// Depends on alb_pkg.
`default_nettype none
module alb_front import alb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     hold,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_data,
  output logic          q_valid,
  output cmd_t          q_cmd,
  input  wire logic     q_pop
);

  localparam int QD  = 2;
  localparam int QPW = $clog2(QD);
  localparam int QCW = $clog2(QD + 1);

  logic signed [COORD_W:0] ddx, ddy, adx, ady, dyw;
  logic signed [COORD_W-1:0] ax0, ay0, ax1, ay1;
  logic steep;
  cmd_t cmd_c;

  always_comb begin
    ddx = (COORD_W+1)'(in_data.end_x) - (COORD_W+1)'(in_data.start_x);
    ddy = (COORD_W+1)'(in_data.end_y) - (COORD_W+1)'(in_data.start_y);
    adx = ddx[COORD_W] ? -ddx : ddx;
    ady = ddy[COORD_W] ? -ddy : ddy;
    steep = ady > adx;
    ax0 = steep ? in_data.start_y : in_data.start_x;
    ay0 = steep ? in_data.start_x : in_data.start_y;
    ax1 = steep ? in_data.end_y : in_data.end_x;
    ay1 = steep ? in_data.end_x : in_data.end_y;
    cmd_c.kind     = in_data.kind;
    cmd_c.steep    = steep;
    cmd_c.color    = {in_data.red, in_data.green, in_data.blue};
    cmd_c.read_col = in_data.read_col;
    cmd_c.read_row = in_data.read_row;
    if (ax0 > ax1) begin
      cmd_c.x0 = ax1;
      cmd_c.y0 = ay1;
      cmd_c.x1 = ax0;
    end else begin
      cmd_c.x0 = ax0;
      cmd_c.y0 = ay0;
      cmd_c.x1 = ax1;
    end
    cmd_c.dx = COORD_W'((COORD_W+1)'(cmd_c.x1) - (COORD_W+1)'(cmd_c.x0));
    dyw = (COORD_W+1)'(ax0 > ax1 ? ay0 : ay1) - (COORD_W+1)'(cmd_c.y0);
    cmd_c.dy_neg = dyw[COORD_W];
    cmd_c.dy_mag = COORD_W'(dyw[COORD_W] ? -dyw : dyw);
  end

  cmd_t           entry [QD];
  logic [QPW-1:0] wp, rp;
  logic [QCW-1:0] cnt;
  logic           push;

  assign in_ready = (cnt < QCW'(QD)) && !hold;
  assign push     = in_valid && in_ready;
  assign q_valid  = cnt != '0;
  assign q_cmd    = entry[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wp] <= cmd_c;
    end
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= QPW'(wp + 1'b1);
      if (q_pop) rp <= QPW'(rp + 1'b1);
      cnt <= QCW'(cnt + QCW'(push) - QCW'(q_pop));
    end
  end

endmodule
`default_nettype wire

[src/alb_back.sv]
// Back end of the line blender: frame store, gradient divider, column
// sequencer with read-modify-write blending, clear sweep and result register.
// Depends on alb_pkg.
`default_nettype none
module alb_back import alb_pkg::*; #(
  parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [CFG_W-1:0] image_width,
  input  wire logic [CFG_W-1:0] image_height,
  input  wire logic             q_valid,
  input  wire cmd_t             q_cmd,
  output logic                  q_pop,
  output logic                  busy,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_word_t             out_data
);

  localparam int CF    = COORD_FRAC_BITS;
  localparam int YF    = CF + GRAD_FRAC;
  localparam int XW    = COORD_W + 2;
  localparam int PW    = COORD_W + 4;
  localparam int GRW   = GRAD_FRAC + 2;
  localparam int YW    = COORD_W + GRAD_FRAC + 4;
  localparam int NW    = COORD_W + GRAD_FRAC + 1;
  localparam int DCW   = $clog2(NW + 1);
  localparam int BW    = YF + 11;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDRW = $clog2(DEPTH);
  localparam int COLW  = $clog2(MAX_WIDTH);
  localparam int ROWW  = $clog2(MAX_HEIGHT);
  localparam logic [COORD_W:0] HALF_C = (COORD_W+1)'(1) << (CF - 1);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_WIPE = 9'b000000010,
    ST_DIV  = 9'b000000100,
    ST_MUL  = 9'b000001000,
    ST_INIT = 9'b000010000,
    ST_COL  = 9'b000100000,
    ST_BLA  = 9'b001000000,
    ST_BLB  = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_t;

  function automatic logic signed [XW-1:0] round_c(input logic signed [COORD_W-1:0] c);
    logic signed [COORD_W:0] cx;
    logic [COORD_W:0] mag, r;
    cx  = (COORD_W+1)'(c);
    mag = cx[COORD_W] ? -cx : cx;
    r   = (mag + HALF_C) >> CF;
    return cx[COORD_W] ? -XW'(r) : XW'(r);
  endfunction

  function automatic logic [ADDRW-1:0] addr_of(input logic [PW-1:0] px, input logic [PW-1:0] py);
    return ADDRW'(ADDRW'(py[ROWW-1:0]) * ADDRW'(MAX_WIDTH)) + ADDRW'(px[COLW-1:0]);
  endfunction

  function automatic logic [23:0] blend_px(input logic [23:0] dst, input logic [23:0] src,
                                           input logic [YF:0] w);
    logic [23:0] res;
    logic signed [8:0] diff;
    logic signed [BW-1:0] num;
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      diff = $signed({1'b0, src[ch*8 +: 8]}) - $signed({1'b0, dst[ch*8 +: 8]});
      num  = (BW'($signed({1'b0, dst[ch*8 +: 8]})) <<< YF)
           + BW'(diff) * BW'($signed({1'b0, w}))
           + (BW'(1) <<< (YF - 1));
      res[ch*8 +: 8] = num[YF +: 8];
    end
    return res;
  endfunction

  state_t state;
  logic [SIZE_W-1:0] aw, ah, lim_c;

  // Line registers.
  logic                      steep, dy_neg;
  logic signed [COORD_W-1:0] x0, y0;
  logic [COORD_W-1:0]        dx;
  logic [23:0]               color;
  logic [NW-1:0]             dnum;
  logic [COORD_W-1:0]        drem;
  logic [GRAD_FRAC:0]        dquo;
  logic [DCW-1:0]            dcnt;
  logic signed [GRW-1:0]     grad;
  logic signed [XW-1:0]      lo, hi, x;
  logic signed [YW-1:0]      y, prod;
  logic [ADDRW-1:0]          pa_addr, pb_addr;
  logic                      pa_ok, pb_ok;
  logic [YF:0]               w0, w1;

  // Sweep and result registers.
  logic [ADDRW-1:0] wipe_addr;
  logic [23:0]      wipe_color;
  logic             res_is_read, rd_ok;
  logic             res_valid;
  out_word_t        res_data;

  // Frame store.
  logic [23:0]      mem [DEPTH];
  logic [23:0]      rd_data;
  logic             rd_en, wr_en;
  logic [ADDRW-1:0] rd_addr, wr_addr;
  logic [23:0]      wr_data;

  // Combinational helpers.
  logic signed [XW-1:0] lo_c, hi_c, lim_m1;
  logic signed [XW-1:0] col_off;
  logic [COORD_W:0]     dshift;
  logic                 dbit;
  logic signed [PW-1:0] iy, iy1, xp, pax, pay, pbx, pby;
  logic                 pa_ok_c, pb_ok_c;
  logic [ADDRW-1:0]     pa_addr_c, pb_addr_c;
  logic [YF-1:0]        frac;
  logic                 load_res;

  assign aw = (SIZE_W'(image_width) > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH)
                                                          : SIZE_W'(image_width);
  assign ah = (SIZE_W'(image_height) > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT)
                                                            : SIZE_W'(image_height);

  always_comb begin
    lim_c  = q_cmd.steep ? ah : aw;
    lim_m1 = XW'($signed({1'b0, lim_c}) - 1);
    lo_c   = round_c(q_cmd.x0);
    hi_c   = round_c(q_cmd.x1);
    if (lo_c < 0) lo_c = '0;
    if (hi_c > lim_m1) hi_c = lim_m1;

    col_off = (lo <<< CF) - XW'(x0);
    dshift  = {drem, dnum[NW-1]};
    dbit    = dshift >= {1'b0, dx};

    iy   = PW'(y >>> YF);
    iy1  = iy + PW'(1);
    frac = y[YF-1:0];
    xp   = PW'(x);
    pax  = steep ? iy : xp;
    pay  = steep ? xp : iy;
    pbx  = steep ? iy1 : xp;
    pby  = steep ? xp : iy1;
    pa_ok_c = !pax[PW-1] && !pay[PW-1] && ($unsigned(pax) < PW'(aw))
              && ($unsigned(pay) < PW'(ah));
    pb_ok_c = !pbx[PW-1] && !pby[PW-1] && ($unsigned(pbx) < PW'(aw))
              && ($unsigned(pby) < PW'(ah));
    pa_addr_c = addr_of(pax, pay);
    pb_addr_c = addr_of(pbx, pby);
  end

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign load_res = (state == ST_DONE) && (!res_valid || out_ready);

  // Memory port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pa_addr_c;
    wr_en   = 1'b0;
    wr_addr = wipe_addr;
    wr_data = wipe_color;
    case (state)
      ST_IDLE: begin
        rd_en   = q_pop && (q_cmd.kind == KIND_READ);
        rd_addr = addr_of(PW'(q_cmd.read_col), PW'(q_cmd.read_row));
      end
      ST_WIPE: begin
        wr_en = 1'b1;
      end
      ST_COL: begin
        rd_en = 1'b1;
      end
      ST_BLA: begin
        wr_en   = pa_ok;
        wr_addr = pa_addr;
        wr_data = blend_px(rd_data, color, w0);
        rd_en   = 1'b1;
        rd_addr = pb_addr;
      end
      ST_BLB: begin
        wr_en   = pb_ok;
        wr_addr = pb_addr;
        wr_data = blend_px(rd_data, color, w1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_WIPE;
      wipe_addr  <= '0;
      wipe_color <= '0;
      busy       <= 1'b1;
      res_valid  <= 1'b0;
    end else begin
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            res_is_read <= 1'b0;
            case (q_cmd.kind)
              KIND_DRAW: begin
                steep  <= q_cmd.steep;
                x0     <= q_cmd.x0;
                y0     <= q_cmd.y0;
                dx     <= q_cmd.dx;
                dy_neg <= q_cmd.dy_neg;
                color  <= q_cmd.color;
                lo     <= lo_c;
                hi     <= hi_c;
                dnum   <= NW'({q_cmd.dy_mag, {GRAD_FRAC{1'b0}}}) + NW'(q_cmd.dx >> 1);
                drem   <= '0;
                dquo   <= '0;
                dcnt   <= DCW'(NW);
                if (q_cmd.dx == '0) begin
                  grad  <= GRW'(1) <<< GRAD_FRAC;
                  state <= ST_MUL;
                end else begin
                  state <= ST_DIV;
                end
              end
              KIND_CLEAR: begin
                wipe_color <= q_cmd.color;
                wipe_addr  <= '0;
                state      <= ST_WIPE;
              end
              KIND_READ: begin
                res_is_read <= 1'b1;
                rd_ok <= (SIZE_W'(q_cmd.read_col) < SIZE_W'(MAX_WIDTH))
                      && (SIZE_W'(q_cmd.read_row) < SIZE_W'(MAX_HEIGHT));
                state <= ST_DONE;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_WIPE: begin
          if (wipe_addr == ADDRW'(DEPTH - 1)) begin
            busy  <= 1'b0;
            state <= busy ? ST_IDLE : ST_DONE;
          end else begin
            wipe_addr <= ADDRW'(wipe_addr + 1'b1);
          end
        end
        ST_DIV: begin
          if (dcnt == '0) begin
            grad  <= dy_neg ? -GRW'(dquo) : GRW'(dquo);
            state <= ST_MUL;
          end else begin
            drem <= dbit ? COORD_W'(dshift - {1'b0, dx}) : dshift[COORD_W-1:0];
            dquo <= {dquo[GRAD_FRAC-1:0], dbit};
            dnum <= dnum << 1;
            dcnt <= DCW'(dcnt - 1'b1);
          end
        end
        ST_MUL: begin
          prod  <= grad * col_off;
          x     <= lo;
          state <= ST_INIT;
        end
        ST_INIT: begin
          y     <= (YW'(y0) <<< GRAD_FRAC) + prod;
          state <= (lo > hi) ? ST_DONE : ST_COL;
        end
        ST_COL: begin
          pa_ok   <= pa_ok_c;
          pb_ok   <= pb_ok_c;
          pa_addr <= pa_addr_c;
          pb_addr <= pb_addr_c;
          w0      <= {1'b1, {YF{1'b0}}} - {1'b0, frac};
          w1      <= {1'b0, frac};
          state   <= ST_BLA;
        end
        ST_BLA: begin
          state <= ST_BLB;
        end
        ST_BLB: begin
          if (x == hi) begin
            state <= ST_DONE;
          end else begin
            x     <= x + XW'(1);
            y     <= y + (YW'(grad) <<< CF);
            state <= ST_COL;
          end
        end
        ST_DONE: begin
          if (load_res) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res_data.is_read_data <= res_is_read;
      res_data.pixel_red    <= (res_is_read && rd_ok) ? rd_data[23:16] : 8'd0;
      res_data.pixel_green  <= (res_is_read && rd_ok) ? rd_data[15:8] : 8'd0;
      res_data.pixel_blue   <= (res_is_read && rd_ok) ? rd_data[7:0] : 8'd0;
    end
  end

  assign out_valid = res_valid;
  assign out_data  = res_data;

endmodule
`default_nettype wire

[src/antialiased_line_blender_unit.sv]
// The back end handles one word at a time. A draw runs the divider (37 steps), then a
// read-modify-write per column in states COL, BLA and BLB; a line that collapses to a
// point skips the divider. Reset: synchronous; a sweep over all MAX_WIDTH*MAX_HEIGHT
// addresses (4096 by default) blacks the frame store, and no word is accepted until it
// ends. Registers reset to 64 x 64.
`default_nettype none
module antialiased_line_blender_unit import alb_pkg::*; #(
  parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_word_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_word_t                 out_data
);

  // Active image size registers, used for clipping by the back end.
  logic [CFG_W-1:0] image_width, image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_SIZE;
      image_height <= RESET_SIZE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The front end classifies each word and queues it; the back end owns
  // the frame store and stalls the queue while it works.
  logic busy;
  logic q_valid, q_pop;
  cmd_t q_cmd;

  alb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .hold     (busy),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  alb_back #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_HEIGHT      (MAX_HEIGHT),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .busy         (busy),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

`ifndef SYNTHESIS
  // No word may enter while the store is still being blacked after reset.
  a_no_accept_in_wipe: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready) else $error("word accepted during reset sweep");

  // The back end only takes a queue entry that is there.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("queue popped while empty");

  // Leaving reset always starts the clearing sweep.
  a_wipe_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> busy) else $error("reset sweep not started");
`endif

endmodule
`default_nettype wire

[sim/testbench.sv]
// Testbench for antialiased_line_blender_unit: random and directed line, clear and
// read words checked against a Wu line predictor held in a small scoreboard class.
// Depends on alb_pkg and the block's RTL only.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import alb_pkg::*;

  // The one command code that the package leaves unnamed; the block must answer it
  // with a plain completion word.
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int STORE_W = 64;
  localparam int STORE_H = 64;
  localparam int CYCLE_LIMIT = 2000000;

  // The scoreboard keeps its own copy of the frame store and the two size registers,
  // and predicts one result word for every accepted command word.
  class frame_scoreboard;
    bit [23:0]  pixels[STORE_W*STORE_H];
    bit [6:0]   width_reg;
    bit [6:0]   height_reg;
    out_word_t  pending[$];
    int         errors;
    int         checked;

    function void clear_all();
      foreach (pixels[i]) pixels[i] = 24'd0;
      width_reg = RESET_SIZE;
      height_reg = RESET_SIZE;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_IMAGE_WIDTH) width_reg = val;
      else if (idx == REG_IMAGE_HEIGHT) height_reg = val;
    endfunction

    // Mixes the line color into one pixel with weight w (24 fraction bits),
    // rounding half up; pixels outside the active image are left alone.
    function void mix_pixel(longint px, longint py, bit [23:0] color, longint w,
                            longint aw, longint ah);
      bit [23:0] old_px;
      bit [23:0] new_px;
      longint d;
      longint s;
      longint num;
      if (px < 0 || px >= aw || py < 0 || py >= ah) return;
      old_px = pixels[py*STORE_W + px];
      for (int ch = 0; ch < 3; ch++) begin
        d = longint'(old_px[16-8*ch +: 8]);
        s = longint'(color[16-8*ch +: 8]);
        num = (d <<< 24) + (s - d) * w + (longint'(1) <<< 23);
        new_px[16-8*ch +: 8] = 8'(num >>> 24);
      end
      pixels[py*STORE_W + px] = new_px;
    endfunction

    function longint round_px(longint c);
      if (c >= 0) return (c + 128) >>> 8;
      return -((-c + 128) >>> 8);
    endfunction

    function void predict_stroke(in_word_t w);
      longint x0, y0, x1, y1, t, dx, dy, grad, lo, hi, lim, y, iy, frac, aw, ah;
      longint mag;
      bit steep;
      bit [23:0] color;
      x0 = longint'(w.start_x);
      y0 = longint'(w.start_y);
      x1 = longint'(w.end_x);
      y1 = longint'(w.end_y);
      color = {w.red, w.green, w.blue};
      aw = (width_reg > STORE_W) ? STORE_W : width_reg;
      ah = (height_reg > STORE_H) ? STORE_H : height_reg;
      steep = ((y1 > y0) ? y1 - y0 : y0 - y1) > ((x1 > x0) ? x1 - x0 : x0 - x1);
      if (steep) begin
        t = x0; x0 = y0; y0 = t;
        t = x1; x1 = y1; y1 = t;
      end
      if (x0 > x1) begin
        t = x0; x0 = x1; x1 = t;
        t = y0; y0 = y1; y1 = t;
      end
      dx = x1 - x0;
      dy = y1 - y0;
      if (dx == 0) begin
        grad = 1 <<< 16;
      end else begin
        mag = ((dy < 0) ? -dy : dy) <<< 16;
        grad = (mag + dx / 2) / dx;
        if (dy < 0) grad = -grad;
      end
      lo = round_px(x0);
      hi = round_px(x1);
      lim = steep ? ah : aw;
      if (lo < 0) lo = 0;
      if (hi > lim - 1) hi = lim - 1;
      for (longint x = lo; x <= hi; x++) begin
        y = (y0 <<< 16) + grad * ((x <<< 8) - x0);
        iy = y >>> 24;
        frac = y - (iy <<< 24);
        if (steep) begin
          mix_pixel(iy, x, color, (longint'(1) <<< 24) - frac, aw, ah);
          mix_pixel(iy + 1, x, color, frac, aw, ah);
        end else begin
          mix_pixel(x, iy, color, (longint'(1) <<< 24) - frac, aw, ah);
          mix_pixel(x, iy + 1, color, frac, aw, ah);
        end
      end
    endfunction

    function void note_command(in_word_t w);
      out_word_t r;
      r = '0;
      case (w.kind)
        KIND_DRAW: predict_stroke(w);
        KIND_CLEAR: foreach (pixels[i]) pixels[i] = {w.red, w.green, w.blue};
        KIND_READ: begin
          r.is_read_data = 1'b1;
          {r.pixel_red, r.pixel_green, r.pixel_blue} =
            pixels[w.read_row*STORE_W + w.read_col];
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      checked++;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.is_read_data !== want.is_read_data) begin
        $error("is_read_data: expected %0d, got %0d", want.is_read_data, got.is_read_data);
        errors++;
      end
      if (got.pixel_red !== want.pixel_red) begin
        $error("pixel_red: expected %0d, got %0d", want.pixel_red, got.pixel_red);
        errors++;
      end
      if (got.pixel_green !== want.pixel_green) begin
        $error("pixel_green: expected %0d, got %0d", want.pixel_green, got.pixel_green);
        errors++;
      end
      if (got.pixel_blue !== want.pixel_blue) begin
        $error("pixel_blue: expected %0d, got %0d", want.pixel_blue, got.pixel_blue);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_word_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_data;

  frame_scoreboard sb = new();
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  calm = 1'b0;      // when set, neither side idles
  int  n_draw = 0, n_clear = 0, n_read = 0, n_spare = 0, n_settings = 0;

  antialiased_line_blender_unit u_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Receiver side. Signals read right after the edge still hold their pre-edge
  // values, so a word counts as accepted exactly when the block saw it so.
  // The ready line is then re-driven with mostly short stalls and a few long ones.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      int r;
      r = $urandom_range(0, 99);
      if (calm || r >= 20) out_ready <= 1'b1;
      else begin
        out_ready <= 1'b0;
        stall_left <= (r < 17) ? $urandom_range(0, 3) : $urandom_range(15, 80);
      end
    end
  end

  function automatic int sender_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offers one word and holds it until the block takes it. The valid line stays
  // high across back-to-back words and is only lowered for a gap or a drain.
  task automatic send_word(in_word_t w);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_command(w);
    case (w.kind)
      KIND_DRAW: n_draw++;
      KIND_CLEAR: n_clear++;
      KIND_READ: n_read++;
      default: n_spare++;
    endcase
  endtask

  // Stops sending and waits until every expected word has come back, then lets
  // a few more cycles go by so the block is surely idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // The enable is dropped once the write has been clocked in and the task returns at a
  // later edge, so a following write starts at a fresh time step.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    drain();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    n_settings++;
  endtask

  function automatic in_word_t line_word(int x0, int y0, int x1, int y1,
                                         logic [23:0] color);
    in_word_t w;
    w = '0;
    w.kind = KIND_DRAW;
    w.start_x = COORD_W'(x0);
    w.start_y = COORD_W'(y0);
    w.end_x = COORD_W'(x1);
    w.end_y = COORD_W'(y1);
    {w.red, w.green, w.blue} = color;
    return w;
  endfunction

  function automatic in_word_t read_word(int col, int row);
    in_word_t w;
    w = '0;
    w.kind = KIND_READ;
    w.read_col = 6'(col);
    w.read_row = 6'(row);
    return w;
  endfunction

  // Mostly coordinates a little around the image with a random fraction, now and
  // then any 20-bit value so every bit of the field toggles.
  function automatic logic [COORD_W-1:0] pick_coord();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return COORD_W'($urandom());
    if (r == 1) return ($urandom_range(0, 1) != 0) ? 20'h80000 : 20'h7FFFF;
    return COORD_W'($urandom_range(0, 80*256) - 8*256);
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int r;
    w = '0;
    w.start_x = pick_coord();
    w.start_y = pick_coord();
    w.end_x = pick_coord();
    w.end_y = pick_coord();
    {w.red, w.green, w.blue} = 24'($urandom());
    {w.read_col, w.read_row} = 12'($urandom());
    r = $urandom_range(0, 99);
    if (r < 50) begin
      w.kind = KIND_DRAW;
      // Some lines run exactly along a row, a column or collapse to a point.
      case ($urandom_range(0, 9))
        0: w.end_y = w.start_y;
        1: w.end_x = w.start_x;
        2: begin w.end_x = w.start_x; w.end_y = w.start_y; end
        default: ;
      endcase
    end else if (r < 96) w.kind = KIND_READ;
    else if (r < 98) w.kind = KIND_CLEAR;
    else w.kind = KIND_SPARE;
    return w;
  endfunction

  initial begin
    in_word_t w;
    sb.clear_all();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset size: black store, lines of every shape, the
    // coordinate extremes, a clear and the spare command code.
    calm = 1'b1;
    send_word(read_word(0, 0));
    send_word(read_word(63, 63));
    send_word(line_word(0, 10*256, 63*256, 10*256, 24'hFFFFFF));
    send_word(read_word(40, 10));
    send_word(line_word(5*256+77, 60*256+200, 20*256+13, 2*256+128, 24'hFF8000));
    send_word(line_word(30*256, 3*256, 30*256, 50*256, 24'h00FF7F));
    send_word(line_word(12*256+128, 12*256+128, 12*256+128, 12*256+128, 24'h123456));
    send_word(line_word(-3*256-128, -5*256, 70*256, 40*256+99, 24'h0000FF));
    send_word(line_word(-524288, -524288, 524287, 524287, 24'hA5A5A5));
    send_word(line_word(524287, -524288, -524288, 524287, 24'h5A5A5A));
    send_word(read_word(12, 12));
    send_word(read_word(30, 20));
    w = '0;
    w.kind = KIND_SPARE;
    send_word(w);
    w = '0;
    w.kind = KIND_CLEAR;
    {w.red, w.green, w.blue} = 24'h336699;
    send_word(w);
    send_word(read_word(63, 0));
    send_word(line_word(1*256, 1*256, 62*256, 30*256, 24'h000000));
    send_word(read_word(31, 15));
    calm = 1'b0;

    // Pause mid-stream until the block has answered everything.
    drain();

    // Random phases over a range of active sizes, including zero and
    // values past the store size.
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: set_size(7'd64, 7'd64);
        1: set_size(7'd1, 7'd1);
        2: set_size(7'd127, 7'd100);
        3: set_size(7'd0, 7'd64);
        4: set_size(7'd23, 7'd0);
        5: set_size(7'd40, 7'd17);
        default: set_size(7'd64, 7'd64);
      endcase
      calm = (phase == 5);
      for (int i = 0; i < 100; i++) begin
        send_word(random_word());
        if (i == 50 && phase == 2) drain();
      end
    end

    drain();
    repeat (100) @(posedge clk);
    $display("testbench: %0d draws, %0d reads, %0d clears, %0d spare words, %0d results",
             n_draw, n_read, n_clear, n_spare, sb.checked);
    $display("testbench: %0d size settings from 0 up to 127", n_settings);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      if (sb.pending.size() > 0) $error("%0d results never arrived", sb.pending.size());
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
